@@ hw/rtl/msqm_pkg.sv @@
// Shared constants, codes and types of the multi-list stack and queue manager.
package msqm_pkg;

    localparam int NUM_LISTS_DEF  = 16;
    localparam int POOL_NODES_DEF = 256;
    localparam int DATA_BITS_DEF  = 32;

    localparam int OP_BITS     = 2;
    localparam int ID_BITS     = 4;
    localparam int VALUE_BITS  = 32;
    localparam int STATUS_BITS = 3;

    localparam logic [OP_BITS-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_BITS-1:0] OP_PUSH   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_POP    = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_DONE    = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_POPPED  = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_EXISTS  = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_MISSING = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd5;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

@@ hw/rtl/multi_stack_queue_manager.sv @@
// Top level: numbered stacks and queues built from linked nodes in a shared pool.
// A request is taken in S_IDLE, where it addresses the registered read of the node memories;
// its result is registered when S_EXEC commits, which waits while the previous result is
// still stalled on the output. A new request is taken only after that commit, in S_IDLE
// again; the write-back to the node memories happens at the commit.
// Reset (rst_n low, asynchronous) clears the list flags, counts and pool counters; head and
// tail pointers and node memories are not cleared.
module multi_stack_queue_manager
    import msqm_pkg::*;
#(
    parameter int NUM_LISTS  = NUM_LISTS_DEF,
    parameter int POOL_NODES = POOL_NODES_DEF,
    parameter int DATA_BITS  = DATA_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [OP_BITS-1:0]            op,
    input  logic [ID_BITS-1:0]            list_id,
    input  logic                          kind,
    input  logic signed [VALUE_BITS-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [STATUS_BITS-1:0]        status,
    output logic signed [VALUE_BITS-1:0]  popped_value
);

    localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int IW = (LW > ID_BITS) ? LW : ID_BITS;
    localparam int NW = $clog2(POOL_NODES);
    localparam int CW = $clog2(POOL_NODES + 1);
    localparam int MW = (DATA_BITS > VALUE_BITS) ? DATA_BITS : VALUE_BITS;

    state_t state_reg, state_next;

    logic [OP_BITS-1:0]   op_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic                 kind_reg;
    logic [DATA_BITS-1:0] val_reg;

    logic          exists_reg [NUM_LISTS];
    logic          exists_next [NUM_LISTS];
    logic          queue_reg [NUM_LISTS];
    logic          queue_next [NUM_LISTS];
    logic [CW-1:0] count_reg [NUM_LISTS];
    logic [CW-1:0] count_next [NUM_LISTS];
    logic [NW-1:0] head_reg [NUM_LISTS];
    logic [NW-1:0] head_next [NUM_LISTS];
    logic [NW-1:0] tail_reg [NUM_LISTS];
    logic [NW-1:0] tail_next [NUM_LISTS];

    logic [CW-1:0] fresh_reg, fresh_next;
    logic [NW-1:0] rhead_reg, rhead_next;
    logic [CW-1:0] rcount_reg, rcount_next;

    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_BITS-1:0]  status_reg, status_next;
    logic [VALUE_BITS-1:0]   popped_reg, popped_next;

    logic                 accept;
    logic                 commit;
    logic                 out_free;
    logic [OP_BITS-1:0]   op_sel;
    logic [ID_BITS-1:0]   id_sel;
    logic [IW-1:0]        id_wide;
    logic                 id_ok;
    logic [LW-1:0]        idx;
    logic                 have_rec;
    logic                 have_fresh;
    logic [NW-1:0]        new_node;
    logic [MW-1:0]        val_wide;
    logic [MW-1:0]        pop_wide;

    logic                 data_we;
    logic [NW-1:0]        data_waddr;
    logic [DATA_BITS-1:0] data_wdata;
    logic [NW-1:0]        data_raddr;
    logic [DATA_BITS-1:0] data_rdata;
    logic                 link_we;
    logic [NW-1:0]        link_waddr;
    logic [NW-1:0]        link_wdata;
    logic [NW-1:0]        link_raddr;
    logic [NW-1:0]        link_rdata;

    msqm_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (POOL_NODES)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    msqm_ram #(
        .WIDTH (NW),
        .DEPTH (POOL_NODES)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    assign in_stall     = (state_reg != S_IDLE);
    assign accept       = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;
    assign commit       = (state_reg == S_EXEC) && out_free;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_value = $signed(popped_reg);

    // In idle the request ports address the read; afterwards the held request does.
    assign op_sel     = (state_reg == S_IDLE) ? op : op_reg;
    assign id_sel     = (state_reg == S_IDLE) ? list_id : id_reg;
    assign id_wide    = IW'(id_sel);
    assign id_ok      = (32'(id_sel) < 32'(NUM_LISTS));
    assign idx        = id_ok ? id_wide[LW-1:0] : '0;
    assign have_rec   = (rcount_reg != '0);
    assign have_fresh = (fresh_reg < CW'(POOL_NODES));
    assign new_node   = have_rec ? rhead_reg : fresh_reg[NW-1:0];
    assign val_wide   = MW'($unsigned(value));
    assign pop_wide   = MW'(data_rdata);

    assign data_raddr = head_reg[idx];
    assign link_raddr = (op_sel == OP_POP) ? head_reg[idx] : rhead_reg;

    always_comb
    begin : next_state_logic
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin : exec_logic
        status_next = ST_DONE;
        popped_next = '0;
        data_we     = 1'b0;
        data_waddr  = new_node;
        data_wdata  = val_reg;
        link_we     = 1'b0;
        link_waddr  = new_node;
        link_wdata  = head_reg[idx];
        exists_next = exists_reg;
        queue_next  = queue_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        fresh_next  = fresh_reg;
        rhead_next  = rhead_reg;
        rcount_next = rcount_reg;

        if (commit && (op_reg == OP_CREATE || op_reg == OP_PUSH || op_reg == OP_POP))
        begin
            priority if (!id_ok)
            begin
                status_next = ST_MISSING;
            end
            else if (op_reg == OP_CREATE)
            begin
                if (exists_reg[idx])
                begin
                    status_next = ST_EXISTS;
                end
                else
                begin
                    exists_next[idx] = 1'b1;
                    queue_next[idx]  = kind_reg;
                    count_next[idx]  = '0;
                end
            end
            else if (!exists_reg[idx])
            begin
                status_next = ST_MISSING;
            end
            else if (op_reg == OP_PUSH)
            begin
                if (!have_rec && !have_fresh)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    data_we = 1'b1;
                    // take from the recycled list first, then from the fresh counter
                    if (have_rec)
                    begin
                        rhead_next  = link_rdata;
                        rcount_next = rcount_reg - 1'b1;
                    end
                    else
                    begin
                        fresh_next = fresh_reg + 1'b1;
                    end
                    if (queue_reg[idx])
                    begin
                        if (count_reg[idx] == '0)
                        begin
                            head_next[idx] = new_node;
                        end
                        else
                        begin
                            link_we    = 1'b1;
                            link_waddr = tail_reg[idx];
                            link_wdata = new_node;
                        end
                        tail_next[idx] = new_node;
                    end
                    else
                    begin
                        link_we        = 1'b1;
                        link_waddr     = new_node;
                        link_wdata     = head_reg[idx];
                        head_next[idx] = new_node;
                    end
                    count_next[idx] = count_reg[idx] + 1'b1;
                end
            end
            else
            begin
                if (count_reg[idx] == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    status_next     = ST_POPPED;
                    popped_next     = pop_wide[VALUE_BITS-1:0];
                    head_next[idx]  = link_rdata;
                    count_next[idx] = count_reg[idx] - 1'b1;
                    // release the node onto the recycled list
                    link_we     = 1'b1;
                    link_waddr  = head_reg[idx];
                    link_wdata  = rhead_reg;
                    rhead_next  = head_reg[idx];
                    rcount_next = rcount_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin : output_valid_logic
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            fresh_reg     <= '0;
            rhead_reg     <= '0;
            rcount_reg    <= '0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                exists_reg[i] <= 1'b0;
                queue_reg[i]  <= 1'b0;
                count_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            fresh_reg     <= fresh_next;
            rhead_reg     <= rhead_next;
            rcount_reg    <= rcount_next;
            exists_reg    <= exists_next;
            queue_reg     <= queue_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
        if (accept)
        begin
            op_reg   <= op;
            id_reg   <= list_id;
            kind_reg <= kind;
            val_reg  <= val_wide[DATA_BITS-1:0];
        end
        if (commit)
        begin
            status_reg <= status_next;
            popped_reg <= popped_next;
        end
    end

endmodule

@@ hw/rtl/msqm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
module msqm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/msqm_checker.sv @@
// Port-level checker for the multi-list stack and queue manager, bound to the top level.
module msqm_checker
    import msqm_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [OP_BITS-1:0]           op,
    input logic [ID_BITS-1:0]           list_id,
    input logic                         kind,
    input logic signed [VALUE_BITS-1:0] value,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [STATUS_BITS-1:0]       status,
    input logic signed [VALUE_BITS-1:0] popped_value
);

    // one request at a time: the block is busy right after taking one
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while previous one still in progress");

    // a new result only appears while a request was being processed
    a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a request in progress");

    a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_POPPED |-> popped_value == '0)
        else $error("nonzero popped value on a result that popped nothing");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_FULL)
        else $error("status code out of range");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(popped_value))
        else $error("stalled result changed");

endmodule

bind multi_stack_queue_manager msqm_checker u_msqm_checker (.*);
